>>> rtl/core/aci_pkg.sv
package aci_pkg;

  localparam int TABLE_LEN = 12;
  localparam int IDX_W     = 4;
  localparam int BP_W      = 12;
  localparam int RANGE_W   = 24;
  localparam int OFF_W     = 20;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = OFF_W + RECIP_W;
  localparam int T_W       = 17;
  localparam int CONST_W   = 16;
  localparam int LIN_W     = 24;
  localparam int QUAD_W    = 32;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  localparam logic [BP_W-1:0] BP_DIST [TABLE_LEN] = '{
    12'd7, 12'd13, 12'd20, 12'd32, 12'd50, 12'd65,
    12'd100, 12'd160, 12'd200, 12'd325, 12'd600, 12'd3250
  };

  localparam logic [CONST_W-1:0] CONST_Q15 [TABLE_LEN] = '{
    16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
    16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd32768
  };

  localparam logic [LIN_W-1:0] LIN_Q23 [TABLE_LEN] = '{
    24'd5872026, 24'd2936013, 24'd1845494, 24'd1174405, 24'd754975, 24'd587203,
    24'd377487, 24'd226492, 24'd184549, 24'd117441, 24'd58720, 24'd11744
  };

  localparam logic [QUAD_W-1:0] QUAD_Q30 [TABLE_LEN] = '{
    32'd1932735283, 32'd472446403, 32'd214748365, 32'd75161928,
    32'd34359738, 32'd18253611, 32'd8053064, 32'd3006477,
    32'd2040109, 32'd751619, 32'd214748, 32'd7516
  };

  localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_LEN-1] = '{
    22'd2796203, 22'd2396745, 22'd1398101, 22'd932068, 22'd1118481, 22'd479349,
    22'd279620, 22'd419430, 22'd134218, 22'd61007, 22'd6331
  };

  typedef struct packed {
    logic [RANGE_W-1:0] light;
    logic [IDX_W-1:0]   lo;
    logic [OFF_W-1:0]   off;
    logic               full;
  } seg_word_t;

  function automatic logic [32:0] lerp_fin(input logic [31:0] a, input logic [63:0] p,
                                           input logic neg);
    logic [63:0] dr;
    logic [63:0] s;
    begin
      dr = (p + 64'd32768) >> 16;
      s  = {32'd0, a} + dr;
      if (!neg) begin
        lerp_fin = s[32:0];
      end else if (dr > {32'd0, a}) begin
        lerp_fin = 33'd0;
      end else begin
        lerp_fin = {1'b0, a - dr[31:0]};
      end
    end
  endfunction

endpackage

>>> rtl/core/attenuation_curve_interpolator.sv
// Point-light attenuation from a Q16.8 light range: the range is classified
// against a fixed table of breakpoints (7 to 3250) and the constant (Q1.15),
// linear (Q1.23) and quadratic (Q2.30) terms are interpolated linearly inside
// the segment, with the end entries returned outside the table. One light is
// accepted per clock while the output is not stalled; out_valid for a light
// rises once it has passed the classify register, which loads at the edge
// that accepts it, one queue slot and four arithmetic stages ending in the
// output register. The two-entry queue between the classifier and the
// arithmetic pipeline absorbs output stalls. NUM_BREAKPOINTS selects how
// many leading table entries are used and is limited to 2..12.
module attenuation_curve_interpolator #(
  parameter int NUM_BREAKPOINTS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aci_pkg::RANGE_W-1:0]   in_light_range,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aci_pkg::RANGE_W-1:0]   out_range_echo,
  output logic [aci_pkg::CONST_W-1:0]   out_constant_term,
  output logic [aci_pkg::LIN_W-1:0]     out_linear_term,
  output logic [aci_pkg::QUAD_W-1:0]    out_quadratic_term
);

  localparam int ACTIVE_POINTS =
    (NUM_BREAKPOINTS > aci_pkg::TABLE_LEN) ? aci_pkg::TABLE_LEN :
    ((NUM_BREAKPOINTS < 2) ? 2 : NUM_BREAKPOINTS);

  logic               f_valid;
  logic               f_ready;
  aci_pkg::seg_word_t f_word;
  logic               q_valid;
  logic               q_ready;
  aci_pkg::seg_word_t q_word;

  aci_front #(
    .ACTIVE_POINTS(ACTIVE_POINTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_light_range(in_light_range),
    .word_valid    (f_valid),
    .word_ready    (f_ready),
    .word          (f_word)
  );

  aci_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_word (f_word),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_word  (q_word)
  );

  aci_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .word_valid        (q_valid),
    .word_ready        (q_ready),
    .word              (q_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_range_echo    (out_range_echo),
    .out_constant_term (out_constant_term),
    .out_linear_term   (out_linear_term),
    .out_quadratic_term(out_quadratic_term)
  );

endmodule

>>> rtl/core/aci_front.sv
module aci_front #(
  parameter int ACTIVE_POINTS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aci_pkg::RANGE_W-1:0]   in_light_range,
  output logic                          word_valid,
  input  logic                          word_ready,
  output aci_pkg::seg_word_t            word
);

  logic                        valid_r;
  logic                        valid_nxt;
  aci_pkg::seg_word_t          word_r;
  aci_pkg::seg_word_t          word_nxt;
  logic [aci_pkg::IDX_W-1:0]   lo_c;
  logic                        found_c;
  logic                        low_c;
  logic                        high_c;
  logic [aci_pkg::RANGE_W-1:0] off_c;

  always_comb begin
    lo_c    = aci_pkg::IDX_W'(ACTIVE_POINTS - 2);
    found_c = 1'b0;
    for (int i = 0; i < ACTIVE_POINTS - 1; i++) begin
      if (!found_c &&
          in_light_range <= aci_pkg::RANGE_W'({aci_pkg::BP_DIST[i+1], 8'h00})) begin
        lo_c    = aci_pkg::IDX_W'(i);
        found_c = 1'b1;
      end
    end
    low_c  = in_light_range <= aci_pkg::RANGE_W'({aci_pkg::BP_DIST[0], 8'h00});
    high_c = in_light_range >=
             aci_pkg::RANGE_W'({aci_pkg::BP_DIST[ACTIVE_POINTS-1], 8'h00});
    off_c  = in_light_range - aci_pkg::RANGE_W'({aci_pkg::BP_DIST[lo_c], 8'h00});

    word_nxt.light = in_light_range;
    word_nxt.lo    = lo_c;
    word_nxt.off   = off_c[aci_pkg::OFF_W-1:0];
    word_nxt.full  = 1'b0;
    if (low_c) begin
      word_nxt.lo  = '0;
      word_nxt.off = '0;
    end else if (high_c) begin
      word_nxt.lo   = aci_pkg::IDX_W'(ACTIVE_POINTS - 2);
      word_nxt.off  = '0;
      word_nxt.full = 1'b1;
    end
  end

  assign in_ready   = !valid_r || word_ready;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

>>> rtl/core/aci_queue.sv
module aci_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  aci_pkg::seg_word_t push_word,
  output logic               pop_valid,
  input  logic               pop_ready,
  output aci_pkg::seg_word_t pop_word
);

  aci_pkg::seg_word_t mem_r [2];
  logic [1:0]         count_r;
  logic [1:0]         count_nxt;
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic               push_c;
  logic               pop_c;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_word   = mem_r[rd_ptr_r];
  assign push_c     = push_valid && push_ready;
  assign pop_c      = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push_c && !pop_c) begin
      count_nxt = count_r + 2'd1;
    end else if (pop_c && !push_c) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_c) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_c) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

>>> rtl/core/aci_back.sv
module aci_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          word_valid,
  output logic                          word_ready,
  input  aci_pkg::seg_word_t            word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aci_pkg::RANGE_W-1:0]   out_range_echo,
  output logic [aci_pkg::CONST_W-1:0]   out_constant_term,
  output logic [aci_pkg::LIN_W-1:0]     out_linear_term,
  output logic [aci_pkg::QUAD_W-1:0]    out_quadratic_term
);

  localparam int PC_W = aci_pkg::CONST_W + aci_pkg::T_W;
  localparam int PL_W = aci_pkg::LIN_W + aci_pkg::T_W;
  localparam int PQ_W = aci_pkg::QUAD_W + aci_pkg::T_W;

  logic                          en;

  logic                          v1_r;
  logic [aci_pkg::RANGE_W-1:0]   dist1_r;
  logic [aci_pkg::IDX_W-1:0]     lo1_r;
  logic                          full1_r;
  logic [aci_pkg::PROD_W-1:0]    prod1_r;

  logic                          v2_r;
  logic [aci_pkg::RANGE_W-1:0]   dist2_r;
  logic [aci_pkg::IDX_W-1:0]     lo2_r;
  logic [aci_pkg::T_W-1:0]       t2_r;
  logic [aci_pkg::T_W-1:0]       t2_nxt;
  logic [aci_pkg::PROD_W:0]      rnd_c;

  logic                          v3_r;
  logic [aci_pkg::RANGE_W-1:0]   dist3_r;
  logic [aci_pkg::CONST_W-1:0]   ac3_r;
  logic [aci_pkg::LIN_W-1:0]     al3_r;
  logic [aci_pkg::QUAD_W-1:0]    aq3_r;
  logic                          nc3_r;
  logic                          nl3_r;
  logic                          nq3_r;
  logic [PC_W-1:0]               pc3_r;
  logic [PL_W-1:0]               pl3_r;
  logic [PQ_W-1:0]               pq3_r;

  logic [aci_pkg::IDX_W-1:0]     hi_c;
  logic [aci_pkg::CONST_W-1:0]   ac_c;
  logic [aci_pkg::CONST_W-1:0]   bc_c;
  logic [aci_pkg::LIN_W-1:0]     al_c;
  logic [aci_pkg::LIN_W-1:0]     bl_c;
  logic [aci_pkg::QUAD_W-1:0]    aq_c;
  logic [aci_pkg::QUAD_W-1:0]    bq_c;
  logic                          nc_c;
  logic                          nl_c;
  logic                          nq_c;
  logic [aci_pkg::CONST_W-1:0]   dc_c;
  logic [aci_pkg::LIN_W-1:0]     dl_c;
  logic [aci_pkg::QUAD_W-1:0]    dq_c;

  logic [32:0]                   rc_c;
  logic [32:0]                   rl_c;
  logic [32:0]                   rq_c;

  logic                          out_valid_r;
  logic [aci_pkg::RANGE_W-1:0]   echo_r;
  logic [aci_pkg::CONST_W-1:0]   cterm_r;
  logic [aci_pkg::LIN_W-1:0]     lterm_r;
  logic [aci_pkg::QUAD_W-1:0]    qterm_r;

  assign en         = !out_valid_r || out_ready;
  assign word_ready = en;

  // t from the segment product, rounded and limited to one
  always_comb begin
    rnd_c = {1'b0, prod1_r} + (aci_pkg::PROD_W+1)'(32768);
    if (full1_r || rnd_c[aci_pkg::PROD_W:16] > (aci_pkg::PROD_W-15)'(aci_pkg::T_ONE)) begin
      t2_nxt = aci_pkg::T_ONE;
    end else begin
      t2_nxt = rnd_c[16 +: aci_pkg::T_W];
    end
  end

  always_comb begin
    hi_c = lo2_r + aci_pkg::IDX_W'(1);
    ac_c = aci_pkg::CONST_Q15[lo2_r];
    bc_c = aci_pkg::CONST_Q15[hi_c];
    al_c = aci_pkg::LIN_Q23[lo2_r];
    bl_c = aci_pkg::LIN_Q23[hi_c];
    aq_c = aci_pkg::QUAD_Q30[lo2_r];
    bq_c = aci_pkg::QUAD_Q30[hi_c];
    nc_c = bc_c < ac_c;
    nl_c = bl_c < al_c;
    nq_c = bq_c < aq_c;
    dc_c = nc_c ? ac_c - bc_c : bc_c - ac_c;
    dl_c = nl_c ? al_c - bl_c : bl_c - al_c;
    dq_c = nq_c ? aq_c - bq_c : bq_c - aq_c;
  end

  always_comb begin
    rc_c = aci_pkg::lerp_fin(32'(ac3_r), 64'(pc3_r), nc3_r);
    rl_c = aci_pkg::lerp_fin(32'(al3_r), 64'(pl3_r), nl3_r);
    rq_c = aci_pkg::lerp_fin(aq3_r, 64'(pq3_r), nq3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= word_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist1_r <= word.light;
      lo1_r   <= word.lo;
      full1_r <= word.full;
      prod1_r <= aci_pkg::PROD_W'(word.off) *
                 aci_pkg::PROD_W'(aci_pkg::SEG_RECIP[word.lo]);

      dist2_r <= dist1_r;
      lo2_r   <= lo1_r;
      t2_r    <= t2_nxt;

      dist3_r <= dist2_r;
      ac3_r   <= ac_c;
      al3_r   <= al_c;
      aq3_r   <= aq_c;
      nc3_r   <= nc_c;
      nl3_r   <= nl_c;
      nq3_r   <= nq_c;
      pc3_r   <= PC_W'(dc_c) * PC_W'(t2_r);
      pl3_r   <= PL_W'(dl_c) * PL_W'(t2_r);
      pq3_r   <= PQ_W'(dq_c) * PQ_W'(t2_r);

      echo_r  <= dist3_r;
      cterm_r <= (rc_c > 33'(16'hFFFF)) ? 16'hFFFF : rc_c[aci_pkg::CONST_W-1:0];
      lterm_r <= (rl_c > 33'(24'hFFFFFF)) ? 24'hFFFFFF : rl_c[aci_pkg::LIN_W-1:0];
      qterm_r <= rq_c[32] ? 32'hFFFFFFFF : rq_c[aci_pkg::QUAD_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_range_echo     = echo_r;
  assign out_constant_term  = cterm_r;
  assign out_linear_term    = lterm_r;
  assign out_quadratic_term = qterm_r;

endmodule
